>>> src/gne_pkg.sv
// ----------------------------------------------------------------------------
// gne_pkg
// Shared types, constants and the gray conversion used by the edge detector.
// ----------------------------------------------------------------------------
package gne_pkg;

  localparam int PIX_W        = 8;
  localparam int THRESHOLD_W  = 8;
  localparam int LINE_WIDTH_W = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [THRESHOLD_W-1:0]  THRESHOLD_RESET  = 8'd50;
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 12'd640;

  // Q8 luma weights, they sum to 256
  localparam logic [7:0] WEIGHT_FIRST  = 8'd77;
  localparam logic [7:0] WEIGHT_SECOND = 8'd150;
  localparam logic [7:0] WEIGHT_THIRD  = 8'd29;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_LINE_WIDTH = 2'd1
  } cfg_index_e;

  // one classified pixel handed from the front to the back
  typedef struct packed {
    logic [PIX_W-1:0] above;     // previous-row gray at this column
    logic [PIX_W-1:0] gray;      // gray of this pixel
    logic             emit;      // pixel produces a result
    logic             last_col;  // pixel sits in the last column
  } item_t;

  // weighted sum of three channel bytes, the top byte of a 16-bit sum
  function automatic logic [PIX_W-1:0] to_gray(input logic [7:0] c0,
                                               input logic [7:0] c1,
                                               input logic [7:0] c2);
    logic [15:0] sum;
    sum = 16'(c0) * 16'(WEIGHT_FIRST) + 16'(c1) * 16'(WEIGHT_SECOND)
        + 16'(c2) * 16'(WEIGHT_THIRD);
    return sum[15:8];
  endfunction

endpackage

>>> src/gne_if.sv
// ----------------------------------------------------------------------------
// gne_if
// Valid/ready channels of the edge detector: pixels, results, configuration.
// ----------------------------------------------------------------------------
interface gne_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_first;
  logic [7:0] chan_second;
  logic [7:0] chan_third;
  logic       frame_start;

  modport source (output valid, chan_first, chan_second, chan_third, frame_start,
                  input ready);
  modport sink   (input valid, chan_first, chan_second, chan_third, frame_start,
                  output ready);
endinterface

interface gne_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_value;
  logic       row_end;
  logic       last_of_run;

  modport source (output valid, edge_value, row_end, last_of_run, input ready);
  modport sink   (input valid, edge_value, row_end, last_of_run, output ready);
endinterface

interface gne_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/gne_front.sv
// ----------------------------------------------------------------------------
// gne_front
// Accepts pixels, converts to gray, tracks row and column, reads and updates
// the line store, and hands classified items to the queue.
// ----------------------------------------------------------------------------
module gne_front import gne_pkg::*; #(
  parameter int MaxWidth = 2048
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              chan_first_i,
  input  logic [7:0]              chan_second_i,
  input  logic [7:0]              chan_third_i,
  input  logic                    frame_start_i,
  input  logic [LINE_WIDTH_W-1:0] line_width_i,
  output logic                    item_valid_o,
  output item_t                   item_o,
  input  logic                    item_ready_i
);

  localparam int ColW = (MaxWidth > 2) ? $clog2(MaxWidth) : 1;
  localparam int WW   = ColW + 1;
  localparam int CmpW = (WW > LINE_WIDTH_W) ? WW : LINE_WIDTH_W;

  logic [ColW-1:0]  col_q, col_d;
  logic             pfr_q, pfr_d;
  logic [CmpW-1:0]  lw_ext, w_cmp;
  logic [WW-1:0]    width_use;
  logic [WW-1:0]    col_sel, col_inc;
  logic             pfr_sel;
  logic [ColW-1:0]  col_idx;
  logic [PIX_W-1:0] gray;
  logic             accept;
  logic             s1_valid_q, s1_valid_d;
  logic [PIX_W-1:0] s1_gray_q;
  logic             s1_emit_q, s1_last_q;
  logic [PIX_W-1:0] above_q;
  logic             emit, last_col;

  logic [PIX_W-1:0] line_mem [MaxWidth];

  // width in use: clamp the register to [2, MaxWidth]
  always_comb begin
    lw_ext = CmpW'(line_width_i);
    if (lw_ext < CmpW'(2)) begin
      w_cmp = CmpW'(2);
    end else if (lw_ext > CmpW'(MaxWidth)) begin
      w_cmp = CmpW'(MaxWidth);
    end else begin
      w_cmp = lw_ext;
    end
    width_use = w_cmp[WW-1:0];
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !s1_valid_q || item_ready_i;
  assign gray       = to_gray(chan_first_i, chan_second_i, chan_third_i);

  // column of this pixel, new frame or shrunk width restarts the row
  always_comb begin
    col_sel = frame_start_i ? '0 : {1'b0, col_q};
    pfr_sel = frame_start_i ? 1'b0 : pfr_q;
    if (col_sel >= width_use) begin
      col_sel = '0;
      pfr_sel = 1'b1;
    end
    col_idx  = col_sel[ColW-1:0];
    emit     = pfr_sel && (col_sel != '0);
    last_col = (col_sel == width_use - WW'(1));
    col_inc  = col_sel + WW'(1);
    if (col_inc >= width_use) begin
      col_d = '0;
      pfr_d = 1'b1;
    end else begin
      col_d = col_inc[ColW-1:0];
      pfr_d = pfr_sel;
    end
  end

  // position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      pfr_q <= 1'b0;
    end else if (accept) begin
      col_q <= col_d;
      pfr_q <= pfr_d;
    end
  end

  // line store: old value read out, new gray written at the same column
  always_ff @(posedge clk_i) begin
    if (accept) begin
      above_q          <= line_mem[col_idx];
      line_mem[col_idx] <= gray;
    end
  end

  // stage register beside the store read data
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (item_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_gray_q <= gray;
      s1_emit_q <= emit;
      s1_last_q <= last_col;
    end
  end

  assign item_valid_o    = s1_valid_q;
  assign item_o.above    = above_q;
  assign item_o.gray     = s1_gray_q;
  assign item_o.emit     = s1_emit_q;
  assign item_o.last_col = s1_last_q;

endmodule

>>> src/gne_queue.sv
// ----------------------------------------------------------------------------
// gne_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module gne_queue import gne_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  item_t       entry_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> src/gne_back.sv
// ----------------------------------------------------------------------------
// gne_back
// Scores each item against its neighbors and drives the result register,
// adding the row-end marker after the last column.
// ----------------------------------------------------------------------------
module gne_back import gne_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [THRESHOLD_W-1:0] threshold_i,
  input  logic                   item_valid_i,
  output logic                   item_ready_o,
  input  item_t                  item_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic [PIX_W-1:0]       edge_value_o,
  output logic                   row_end_o,
  output logic                   last_of_run_o
);

  logic             res_valid_q, res_valid_d;
  logic [PIX_W-1:0] edge_q, edge_d;
  logic             row_end_q, row_end_d;
  logic             last_q, last_d;
  logic             pend_q, pend_d;
  logic [PIX_W-1:0] left_q, above_left_q;
  logic             can_load, pop;
  logic             hit_above, hit_left, hit_below;
  logic [PIX_W-1:0] edge_score;

  function automatic logic exceeds(input logic [PIX_W-1:0] a,
                                   input logic [PIX_W-1:0] b,
                                   input logic [THRESHOLD_W-1:0] thr);
    logic [PIX_W-1:0] diff;
    diff = (a > b) ? (a - b) : (b - a);
    return diff > thr;
  endfunction

  assign can_load     = !res_valid_q || res_ready_i;
  assign pop          = can_load && !pend_q && item_valid_i;
  assign item_ready_o = can_load && !pend_q;

  // centre is the previous-row pixel one to the left
  always_comb begin
    hit_above  = exceeds(above_left_q, item_i.above, threshold_i);
    hit_left   = exceeds(above_left_q, left_q, threshold_i);
    hit_below  = exceeds(above_left_q, item_i.gray, threshold_i);
    edge_score = ((hit_above && hit_left) || (hit_above && hit_below) ||
                  (hit_left && hit_below)) ? EDGE_ON : EDGE_OFF;
  end

  // result register load
  always_comb begin
    res_valid_d = res_valid_q;
    edge_d      = edge_q;
    row_end_d   = row_end_q;
    last_d      = last_q;
    pend_d      = pend_q;
    if (can_load) begin
      res_valid_d = 1'b0;
      if (pend_q) begin
        res_valid_d = 1'b1;
        edge_d      = EDGE_OFF;
        row_end_d   = 1'b1;
        last_d      = 1'b1;
        pend_d      = 1'b0;
      end else if (pop && item_i.emit) begin
        res_valid_d = 1'b1;
        edge_d      = edge_score;
        row_end_d   = 1'b0;
        last_d      = !item_i.last_col;
        pend_d      = item_i.last_col;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q  <= 1'b0;
      pend_q       <= 1'b0;
      left_q       <= '0;
      above_left_q <= '0;
    end else begin
      res_valid_q <= res_valid_d;
      pend_q      <= pend_d;
      if (pop) begin
        left_q       <= item_i.gray;
        above_left_q <= item_i.above;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q    <= edge_d;
    row_end_q <= row_end_d;
    last_q    <= last_d;
  end

  assign res_valid_o   = res_valid_q;
  assign edge_value_o  = edge_q;
  assign row_end_o     = row_end_q;
  assign last_of_run_o = last_q;

endmodule

>>> src/gray_neighbor_edge_detector.sv
// ----------------------------------------------------------------------------
// gray_neighbor_edge_detector
// Gray conversion and thresholded neighbor-difference edge detection.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order and are taken one per clock while nothing
// downstream holds them back. Each is turned into gray and compared, one
// row and one column late, against its right, lower and lower-right
// neighbors; two or more differences above the threshold give 255. A
// result for the pixel one row up and one column left leaves when a pixel
// arrives; the last column of a row gives a second transaction (0 with
// row_end), during which no item is taken, which is the only sustained
// slowdown. A result passes the line store read stage, one queue entry and
// the result register after its pixel is accepted. The line store is a
// single-port-per-cycle memory of MAX_WIDTH bytes, read and written at the
// same column for each pixel. Configuration writes are always accepted and
// are meant to be done while the stream is idle.
// ----------------------------------------------------------------------------
module gray_neighbor_edge_detector import gne_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  gne_pix_if.sink   pix_i,
  gne_res_if.source res_o,
  gne_cfg_if.sink   cfg_i
);

  logic [THRESHOLD_W-1:0]  threshold_q;
  logic [LINE_WIDTH_W-1:0] line_width_q;
  logic                    cfg_write;
  logic                    front_valid, front_ready;
  item_t                   front_item;
  logic                    back_valid, back_ready;
  item_t                   back_item;

  // configuration registers
  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= THRESHOLD_RESET;
      line_width_q <= LINE_WIDTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_i.index)
        CFG_THRESHOLD:  threshold_q  <= cfg_i.data[THRESHOLD_W-1:0];
        CFG_LINE_WIDTH: line_width_q <= cfg_i.data[LINE_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  gne_front #(
    .MaxWidth (MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (pix_i.valid),
    .in_ready_o    (pix_i.ready),
    .chan_first_i  (pix_i.chan_first),
    .chan_second_i (pix_i.chan_second),
    .chan_third_i  (pix_i.chan_third),
    .frame_start_i (pix_i.frame_start),
    .line_width_i  (line_width_q),
    .item_valid_o  (front_valid),
    .item_o        (front_item),
    .item_ready_i  (front_ready)
  );

  gne_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (back_item)
  );

  gne_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .threshold_i   (threshold_q),
    .item_valid_i  (back_valid),
    .item_ready_o  (back_ready),
    .item_i        (back_item),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .edge_value_o  (res_o.edge_value),
    .row_end_o     (res_o.row_end),
    .last_of_run_o (res_o.last_of_run)
  );

endmodule
